>>> hw/rtl/midi_message_framer_unit_macros.svh
// Assertion macros shared by the checker files of the MIDI message framer.
// Each macro samples on the rising edge of aclk and is disabled while aresetn is low.
`ifndef MIDI_MESSAGE_FRAMER_UNIT_MACROS_SVH
`define MIDI_MESSAGE_FRAMER_UNIT_MACROS_SVH

// Overlapping implication: cons must hold in the same cycle as ante.
`define MMF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: cons must hold in the cycle after ante.
`define MMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message framer package
// Shared status codes, the controller state type and the message length rule.
// ----------------------------------------------------------------------------
package mmf_pkg;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] NO_STATUS   = 8'h00;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WR2  = 4'b0010,
        S_RD   = 4'b0100,
        S_WAIT = 4'b1000
    } state_t;

    // Data bytes that follow a status byte in a fixed-length message.
    function automatic logic [1:0] data_bytes_needed(input logic [7:0] status);
        logic [1:0] n;
        if (status[7:4] == 4'hF) begin
            if (status == 8'hF1 || status == 8'hF3) begin
                n = 2'd1;
            end else if (status == 8'hF2) begin
                n = 2'd2;
            end else begin
                n = 2'd0;
            end
        end else if (status[7:5] == 3'b110) begin
            n = 2'd1;
        end else begin
            n = 2'd2;
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/mmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/midi_message_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message framer
// Assembles MIDI bytes into complete messages with running status and SysEx.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one MIDI byte per request. Bit 7 set marks a status
// byte. Bytes of the open message are stored in a RAM of BUFFER_BYTES entries.
// When a message completes, its bytes leave on the m_ channel in order, one
// per request, with m_last_of_message high on the final byte.
// An input byte is written straight to the RAM, but a data byte that reopens
// a message from running status writes the status first and itself in S_WR2
// (status and data go through the single RAM write port). Emission reads the
// RAM one byte at a time, through S_RD and S_WAIT, and s_ready is low while a
// message is emitted. The output register lets the next byte be accepted while
// the final byte of the previous message still waits on m_ready.
// A stall on m_ready holds the output register and pauses the RAM reads.
// Reset clears the byte count, the running status and the output valid; no
// clearing pass is needed since only bytes written for the open message are
// ever read.
// ----------------------------------------------------------------------------
module midi_message_framer_unit #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_message
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam logic [CW-1:0] SYSEX_DATA_LIMIT = CW'(BUFFER_BYTES - 1);

    mmf_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [7:0]      rs_reg, rs_next;
    logic [7:0]      first_reg, first_next;
    logic [7:0]      pend_reg, pend_next;
    logic [AW-1:0]   rd_idx_reg, rd_idx_next;
    logic [AW-1:0]   last_idx_reg, last_idx_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_byte_reg, m_byte_next;
    logic            m_last_reg, m_last_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [7:0]      ram_rdata;

    mmf_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_BYTES)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rs_next       = rs_reg;
        first_next    = first_reg;
        pend_next     = pend_reg;
        rd_idx_next   = rd_idx_reg;
        last_idx_next = last_idx_reg;
        m_valid_next  = m_valid_reg;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = s_data_byte;
        ram_re        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            mmf_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (s_data_byte[7]) begin
                        if (count_reg != '0 && first_reg == mmf_pkg::SYSEX_START &&
                            s_data_byte == mmf_pkg::SYSEX_END) begin
                            // Close the SysEx block and emit it whole.
                            ram_we        = 1'b1;
                            ram_waddr     = count_reg[AW-1:0];
                            last_idx_next = count_reg[AW-1:0];
                            rd_idx_next   = '0;
                            count_next    = '0;
                            state_next    = mmf_pkg::S_RD;
                        end else begin
                            ram_we     = 1'b1;
                            first_next = s_data_byte;
                            rs_next    = (s_data_byte[7:4] == 4'hF) ?
                                         mmf_pkg::NO_STATUS : s_data_byte;
                            if (s_data_byte != mmf_pkg::SYSEX_START &&
                                mmf_pkg::data_bytes_needed(s_data_byte) == 2'd0) begin
                                last_idx_next = '0;
                                rd_idx_next   = '0;
                                count_next    = '0;
                                state_next    = mmf_pkg::S_RD;
                            end else begin
                                count_next = CW'(1);
                            end
                        end
                    end else if (count_reg == '0) begin
                        // Running status opens a message: status now, data next cycle.
                        if (rs_reg != mmf_pkg::NO_STATUS) begin
                            ram_we     = 1'b1;
                            ram_wdata  = rs_reg;
                            first_next = rs_reg;
                            pend_next  = s_data_byte;
                            state_next = mmf_pkg::S_WR2;
                        end
                    end else if (first_reg == mmf_pkg::SYSEX_START) begin
                        // Keep one entry free for the closing byte.
                        if (count_reg < SYSEX_DATA_LIMIT) begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = count_reg[AW-1:0];
                        if (count_reg == CW'(mmf_pkg::data_bytes_needed(first_reg))) begin
                            last_idx_next = count_reg[AW-1:0];
                            rd_idx_next   = '0;
                            count_next    = '0;
                            state_next    = mmf_pkg::S_RD;
                        end else begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end
            mmf_pkg::S_WR2: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(1);
                ram_wdata = pend_reg;
                if (mmf_pkg::data_bytes_needed(first_reg) == 2'd1) begin
                    last_idx_next = AW'(1);
                    rd_idx_next   = '0;
                    count_next    = '0;
                    state_next    = mmf_pkg::S_RD;
                end else begin
                    count_next = CW'(2);
                    state_next = mmf_pkg::S_IDLE;
                end
            end
            mmf_pkg::S_RD: begin
                ram_re     = 1'b1;
                state_next = mmf_pkg::S_WAIT;
            end
            mmf_pkg::S_WAIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = ram_rdata;
                    m_last_next  = (rd_idx_reg == last_idx_reg);
                    if (rd_idx_reg == last_idx_reg) begin
                        state_next = mmf_pkg::S_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                        state_next  = mmf_pkg::S_RD;
                    end
                end
            end
            default: begin
                state_next = mmf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mmf_pkg::S_IDLE;
            count_reg   <= '0;
            rs_reg      <= mmf_pkg::NO_STATUS;
            first_reg   <= mmf_pkg::NO_STATUS;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rs_reg      <= rs_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
        pend_reg     <= pend_next;
        rd_idx_reg   <= rd_idx_next;
        last_idx_reg <= last_idx_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
    end

    assign s_ready           = (state_reg == mmf_pkg::S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_out_byte        = m_byte_reg;
    assign m_last_of_message = m_last_reg;

endmodule

>>> hw/rtl/mmf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message framer port checker
// Watches the top-level ports and flags framing and handshake violations.
// ----------------------------------------------------------------------------
`include "midi_message_framer_unit_macros.svh"

module mmf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_data_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last_of_message
);

    // A stalled result keeps its byte and marker.
    `MMF_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_last_of_message), "result changed while stalled")

    // No new byte is taken while a message is still being emitted.
    `MMF_ASSERT_SAME(a_no_accept_mid_msg, m_valid && !m_last_of_message, !s_ready, "input ready in the middle of a message")

    // A single-byte real-time message starts emission at once.
    `MMF_ASSERT_NEXT(a_realtime_emits, s_valid && s_ready && s_data_byte[7:3] == 5'b11111, !s_ready, "real-time byte did not start emission")

endmodule

bind midi_message_framer_unit mmf_checker u_mmf_checker (.*);

>>> tb/midi_message_framer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message framer testbench
// Drives MIDI byte streams into the framer with random idle gaps on both
// channels. A local model of the framer predicts every framed byte, and each
// output request is checked against the oldest prediction. Directed tests
// cover every message kind, running status, interrupted messages, SysEx and
// its overflow. A random mix of well-formed messages and noise follows.
// ----------------------------------------------------------------------------
module midi_message_framer_unit_tb;

    localparam int BUFFER_BYTES  = 64;
    localparam int RANDOM_ITEMS  = 52;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 4 * BUFFER_BYTES;
    localparam int MAX_WAIT      = 16;

    // Channel voice operations (low nibble is the channel).
    localparam logic [7:0] NOTE_OFF          = 8'h80;
    localparam logic [7:0] NOTE_ON           = 8'h90;
    localparam logic [7:0] POLY_PRESSURE     = 8'hA0;
    localparam logic [7:0] CONTROL_CHANGE    = 8'hB0;
    localparam logic [7:0] PROGRAM_CHANGE    = 8'hC0;
    localparam logic [7:0] CHANNEL_PRESSURE  = 8'hD0;
    localparam logic [7:0] PITCH_BEND        = 8'hE0;
    // System common and real-time codes.
    localparam logic [7:0] MTC_QUARTER_FRAME = 8'hF1;
    localparam logic [7:0] SONG_POSITION     = 8'hF2;
    localparam logic [7:0] SONG_SELECT       = 8'hF3;
    localparam logic [7:0] SYSTEM_UNDEF_F4   = 8'hF4;
    localparam logic [7:0] TUNE_REQUEST      = 8'hF6;
    localparam logic [7:0] TIMING_CLOCK      = 8'hF8;
    localparam logic [7:0] SYSTEM_RESET      = 8'hFF;
    localparam logic [7:0] MAX_DATA          = 8'h7F;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } framed_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_of_message;

    // Model state of the framer.
    logic [7:0]   open_message[BUFFER_BYTES];
    int unsigned  open_length;
    logic [7:0]   held_status;
    framed_byte_t framed_bytes_due[$];

    int  mismatch_count = 0;
    int  accepted_bytes = 0;
    int  cycle_count = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;

    midi_message_framer_unit #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data_byte(s_data_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_byte(m_out_byte),
        .m_last_of_message(m_last_of_message)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("midi_message_framer_unit_tb failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic int draw_wait(input bit quiet);
        if (quiet || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int message_data_bytes(input logic [7:0] status);
        case (status)
            MTC_QUARTER_FRAME, SONG_SELECT: return 1;
            SONG_POSITION: return 2;
            default: begin
                if (status[7:4] == mmf_pkg::SYSEX_START[7:4]) begin
                    return 0;
                end else if (status[7:5] == PROGRAM_CHANGE[7:5]) begin
                    return 1;
                end
                return 2;
            end
        endcase
    endfunction

    function automatic void store_byte(input logic [7:0] value);
        if (open_length < BUFFER_BYTES) begin
            open_message[open_length] = value;
            open_length++;
        end
    endfunction

    function automatic void release_message();
        framed_byte_t fb;
        for (int k = 0; k < open_length; k++) begin
            fb.data = open_message[k];
            fb.last = (k + 1 == open_length);
            framed_bytes_due.push_back(fb);
        end
        open_length = 0;
    endfunction

    // Updates the model with one accepted byte and queues any framed output.
    function automatic void frame_midi_byte(input logic [7:0] value, output bit dropped);
        dropped = 1'b0;
        if (value[7]) begin
            if (open_length > 0 && open_message[0] == mmf_pkg::SYSEX_START &&
                value == mmf_pkg::SYSEX_END) begin
                store_byte(value);
                release_message();
                return;
            end
            open_length = 0;
            held_status = (value[7:4] == mmf_pkg::SYSEX_START[7:4]) ?
                          mmf_pkg::NO_STATUS : value;
            store_byte(value);
            if (value == mmf_pkg::SYSEX_START) begin
                return;
            end
        end else begin
            if (open_length == 0) begin
                if (held_status == mmf_pkg::NO_STATUS) begin
                    dropped = 1'b1;
                    return;
                end
                store_byte(held_status);
            end
            if (open_message[0] == mmf_pkg::SYSEX_START) begin
                // One slot always stays free for the closing byte.
                if (open_length < BUFFER_BYTES - 1) begin
                    store_byte(value);
                end else begin
                    dropped = 1'b1;
                end
                return;
            end
            store_byte(value);
        end
        if (open_length == message_data_bytes(open_message[0]) + 1) begin
            release_message();
        end
    endfunction

    // Valid stays high across back-to-back requests; it drops only for a gap.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        bit dropped;
        gap = draw_wait(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= value;
        do @(posedge aclk); while (!s_ready);
        frame_midi_byte(value, dropped);
        if (!dropped) begin
            accepted_bytes++;
        end
    endtask

    function automatic logic [7:0] random_data();
        return 8'($urandom_range(0, MAX_DATA));
    endfunction

    function automatic logic [7:0] random_channel_status();
        return {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
    endfunction

    // Output side: random stalls, then check each accepted request in order.
    initial begin
        framed_byte_t due;
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(rx_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (framed_bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          m_out_byte, m_last_of_message));
            end else begin
                due = framed_bytes_due.pop_front();
                if (m_out_byte !== due.data) begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              m_out_byte, due.data));
                end
                if (m_last_of_message !== due.last) begin
                    report_mismatch($sformatf("last_of_message %0b, expected %0b on byte %02h",
                                              m_last_of_message, due.last, due.data));
                end
            end
        end
    end

    task automatic test_orphan_data();
        send_byte(8'h55);
        send_byte(8'h00);
    endtask

    task automatic test_channel_messages();
        send_byte(NOTE_ON);
        send_byte(8'h00);
        send_byte(MAX_DATA);
        send_byte(NOTE_OFF | 8'h0A);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(POLY_PRESSURE | 8'h05);
        send_byte(8'h03);
        send_byte(8'h04);
        send_byte(CHANNEL_PRESSURE | 8'h07);
        send_byte(8'h05);
        send_byte(PITCH_BEND | 8'h0F);
        send_byte(MAX_DATA);
        send_byte(MAX_DATA);
    endtask

    task automatic test_running_status();
        send_byte(8'h40);
        send_byte(8'h41);
        // The control change is cut short by the program change.
        send_byte(CONTROL_CHANGE | 8'h0F);
        send_byte(MAX_DATA);
        send_byte(PROGRAM_CHANGE | 8'h03);
        send_byte(MAX_DATA);
        send_byte(8'h00);
    endtask

    task automatic test_system_messages();
        send_byte(MTC_QUARTER_FRAME);
        send_byte(8'h10);
        send_byte(SONG_POSITION);
        send_byte(8'h00);
        send_byte(MAX_DATA);
        send_byte(SONG_SELECT);
        send_byte(8'h01);
        send_byte(TUNE_REQUEST);
        send_byte(TIMING_CLOCK);
        // System bytes cleared the running status, so this one is dropped.
        send_byte(8'h22);
        send_byte(mmf_pkg::SYSEX_END);
        send_byte(SYSTEM_RESET);
    endtask

    task automatic test_sysex();
        send_byte(mmf_pkg::SYSEX_START);
        send_byte(8'h01);
        send_byte(MAX_DATA);
        send_byte(mmf_pkg::SYSEX_END);
        send_byte(mmf_pkg::SYSEX_START);
        send_byte(mmf_pkg::SYSEX_END);
        send_byte(mmf_pkg::SYSEX_START);
        send_byte(8'h11);
        send_byte(NOTE_ON | 8'h01);
        send_byte(8'h30);
        send_byte(8'h40);
    endtask

    task automatic test_sysex_overflow();
        rx_quiet = 1'b1;
        send_byte(mmf_pkg::SYSEX_START);
        for (int i = 0; i < BUFFER_BYTES + 6; i++) begin
            send_byte(8'(i));
        end
        send_byte(mmf_pkg::SYSEX_END);
        rx_quiet = 1'b0;
    endtask

    task automatic send_random_message();
        int kind;
        int n;
        int count;
        logic [7:0] status;
        kind = $urandom_range(0, 99);
        tx_quiet = ($urandom_range(0, 5) == 0);
        rx_quiet = ($urandom_range(0, 5) == 0);
        if (kind < 15 && held_status != mmf_pkg::NO_STATUS) begin
            repeat (message_data_bytes(held_status)) send_byte(random_data());
        end else if (kind < 55) begin
            status = random_channel_status();
            send_byte(status);
            repeat (message_data_bytes(status)) send_byte(random_data());
        end else if (kind < 67) begin
            case ($urandom_range(0, 3))
                0: status = MTC_QUARTER_FRAME;
                1: status = SONG_POSITION;
                2: status = SONG_SELECT;
                default: status = TUNE_REQUEST;
            endcase
            send_byte(status);
            repeat (message_data_bytes(status)) send_byte(random_data());
        end else if (kind < 75) begin
            // Real-time, undefined, tune request and stray end-of-exclusive codes.
            send_byte(8'($urandom_range(SYSTEM_UNDEF_F4, SYSTEM_RESET)));
        end else if (kind < 86) begin
            if ($urandom_range(0, 7) == 0) begin
                count = $urandom_range(BUFFER_BYTES - 4, BUFFER_BYTES + 6);
            end else begin
                count = $urandom_range(0, 10);
            end
            send_byte(mmf_pkg::SYSEX_START);
            repeat (count) send_byte(random_data());
            if ($urandom_range(0, 5) == 0) begin
                send_byte({1'b1, 7'($urandom_range(0, MAX_DATA))});
            end else begin
                send_byte(mmf_pkg::SYSEX_END);
            end
        end else if (kind < 93) begin
            // A message left incomplete; a later status byte cuts it off, while later data bytes may complete it.
            status = random_channel_status();
            n = $urandom_range(0, message_data_bytes(status) - 1);
            send_byte(status);
            repeat (n) send_byte(random_data());
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic();
        int start_count;
        start_count = accepted_bytes;
        while (accepted_bytes - start_count < RANDOM_ITEMS) begin
            send_random_message();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        open_length = 0;
        held_status = mmf_pkg::NO_STATUS;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_orphan_data();
        test_channel_messages();
        test_running_status();
        test_system_messages();
        test_sysex();
        test_sysex_overflow();
        test_random_traffic();

        s_valid <= 1'b0;
        while (framed_bytes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("midi_message_framer_unit_tb passed");
        end else begin
            $display("midi_message_framer_unit_tb failed");
        end
        $finish;
    end

endmodule
